FILE: hw/rtl/wrw_pkg.sv
// Shared types and constants for the weighted random-walk step engine.
// No dependencies; the interfaces, the divider and the step engine use this package.
`timescale 1ns / 1ps
`default_nettype none
package wrw_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int EDGE_SLOTS    = 65536;
  localparam int PRODUCT_SLOTS = 16384;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int EDGE_AW = $clog2(EDGE_SLOTS);
  localparam int PROD_AW = $clog2(PRODUCT_SLOTS);

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 16;
  localparam int TARGET_W  = 12;
  localparam int WEIGHT_W  = 32;
  localparam int ESTART_W  = 16;
  localparam int ECOUNT_W  = 17;
  localparam int PSTART_W  = 14;
  localparam int PCOUNT_W  = 15;
  localparam int Q16_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [Q16_W-1:0] CONTINUE_RESET = 16'd63898;  // 0.975
  localparam logic [Q16_W-1:0] RATIO_RESET    = 16'd32768;  // 0.5

  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 2'd1;

  localparam logic [CMD_W-1:0] CMD_WRITE_EDGE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_ROW     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_PRODUCT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STEP          = 2'd3;

  // Divider operand widths.
  localparam int DVD_W = 32;
  localparam int DVS_W = 17;

  typedef struct packed {
    logic [ESTART_W-1:0] edge_base;
    logic [ECOUNT_W-1:0] edge_total;
    logic [PSTART_W-1:0] product_base;
    logic [PCOUNT_W-1:0] product_total;
  } row_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [WEIGHT_W-1:0] cum_weight;
  } edge_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wrw_in_if.sv
// Input channel of the walk engine: valid/ready plus one command item.
// Depends on wrw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface wrw_in_if;
  logic                            valid;
  logic                            ready;
  logic [wrw_pkg::CMD_W-1:0]       command;
  logic [wrw_pkg::TARGET_W-1:0]    node;
  logic [wrw_pkg::SLOT_W-1:0]      slot;
  logic [wrw_pkg::TARGET_W-1:0]    target_node;
  logic [wrw_pkg::WEIGHT_W-1:0]    cum_weight;
  logic [wrw_pkg::ESTART_W-1:0]    row_edge_start;
  logic [wrw_pkg::ECOUNT_W-1:0]    row_edge_count;
  logic [wrw_pkg::PSTART_W-1:0]    row_product_start;
  logic [wrw_pkg::PCOUNT_W-1:0]    row_product_count;
  logic [wrw_pkg::Q16_W-1:0]       random_value;

  modport source (output valid, command, node, slot, target_node, cum_weight,
                  row_edge_start, row_edge_count, row_product_start,
                  row_product_count, random_value, input ready);
  modport sink   (input valid, command, node, slot, target_node, cum_weight,
                  row_edge_start, row_edge_count, row_product_start,
                  row_product_count, random_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/wrw_out_if.sv
// Result channel of the walk engine: valid/ready plus one result item.
// Depends on wrw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface wrw_out_if;
  logic                          valid;
  logic                          ready;
  logic [wrw_pkg::TARGET_W-1:0]  next_node;
  logic                          walk_stopped;
  logic                          status;

  modport source (output valid, next_node, walk_stopped, status, input ready);
  modport sink   (input valid, next_node, walk_stopped, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/wrw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/wrw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wrw_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module wrw_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [wrw_pkg::DVD_W-1:0]  dividend,
  input  wire logic [wrw_pkg::DVS_W-1:0]  divisor,
  output logic                            done,
  output logic      [wrw_pkg::DVD_W-1:0]  quotient
);
  import wrw_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule
`default_nettype wire

FILE: hw/rtl/weighted_random_walk_step.sv
// Weighted random-walk step engine: loads and steps over CSR tables in RAM.
// Loads and stopped walks go straight to the result state; steps first divide for u (not when
// cont_r is zero), then weighted steps binary-search the edge row, each probe passing S_SCHK,
// S_SWAIT and S_SCMP, and product-edge steps run the serial divider again for the index.
// One item in flight; the next is taken once the result transfer completes.
// Reset: synchronous; a clearing pass then zeroes all 4096 node-row RAM entries.
`timescale 1ns / 1ps
`default_nettype none
module weighted_random_walk_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wrw_in_if.sink                             in_ch,
  wrw_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [wrw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wrw_pkg::Q16_W-1:0]     cfg_wdata
);
  import wrw_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_DIVU   = 14'b00000000000100,
    S_DECIDE = 14'b00000000001000,
    S_LAST   = 14'b00000000010000,
    S_SCHK   = 14'b00000000100000,
    S_SWAIT  = 14'b00000001000000,
    S_SCMP   = 14'b00000010000000,
    S_TGT    = 14'b00000100000000,
    S_PMUL   = 14'b00001000000000,
    S_PSTART = 14'b00010000000000,
    S_PDIV   = 14'b00100000000000,
    S_PRD    = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [Q16_W-1:0] cont_r;
  logic [Q16_W-1:0] ratio_r;

  // Step datapath.
  logic [NODE_W-1:0]       clr_r;
  logic [ECOUNT_W-1:0]     u_r;
  logic [ESTART_W-1:0]     lo_r;
  logic [ESTART_W-1:0]     hi_r;
  logic [WEIGHT_W+ECOUNT_W-1:0] lhs_r;
  logic [WEIGHT_W+Q16_W-1:0]    rhs_r;
  logic [DVD_W-1:0]        num_r;

  // Result register.
  logic [TARGET_W-1:0] res_node_r;
  logic                res_stop_r;
  logic                res_status_r;

  // Memory ports.
  logic               row_we, row_re;
  logic [NODE_W-1:0]  row_waddr;
  row_t               row_wdata, row_q;
  logic               edge_we, edge_re;
  logic [EDGE_AW-1:0] edge_raddr;
  edge_t              edge_wdata, edge_q;
  logic               prod_we, prod_re;
  logic [PROD_AW-1:0] prod_raddr;
  logic [TARGET_W-1:0] prod_q;

  // Divider.
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quot;
  logic [DVS_W-1:0]  div_dvs;

  logic               in_xfer, is_step, stop_walk, use_weighted;
  logic [ECOUNT_W:0]  mid_sum;
  logic [ESTART_W-1:0] mid;
  logic [DVD_W-1:0]   pidx_full;
  logic [PROD_AW-1:0] pidx;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign is_step   = in_ch.command == CMD_STEP;
  assign stop_walk = in_ch.random_value > cont_r;

  // Weighted branch when the node has no product edges or u falls below the ratio.
  assign use_weighted = (row_q.product_total == '0) || (u_r < {1'b0, ratio_r});

  assign mid_sum = (ECOUNT_W+1)'(lo_r) + (ECOUNT_W+1)'(hi_r);
  assign mid     = mid_sum[ESTART_W:1];

  // Clamp the product index to count - 1.
  assign pidx_full = (div_quot > DVD_W'(row_q.product_total - 1'b1)) ?
                     DVD_W'(row_q.product_total - 1'b1) : div_quot;
  assign pidx      = PROD_AW'(row_q.product_base + pidx_full[PSTART_W-1:0]);

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_r  <= CONTINUE_RESET;
      ratio_r <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONTINUE: cont_r  <= cfg_wdata;
        CFG_RATIO:    ratio_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Row RAM: the clearing pass and row loads share the write port.
  always_comb begin
    row_we    = (state_r == S_CLEAR) ||
                ((state_r == S_IDLE) && in_xfer && (in_ch.command == CMD_WRITE_ROW));
    row_waddr = (state_r == S_CLEAR) ? clr_r : NODE_W'(in_ch.node);
    row_wdata = '0;
    if (state_r != S_CLEAR) begin
      row_wdata.edge_base     = in_ch.row_edge_start;
      row_wdata.edge_total    = in_ch.row_edge_count;
      row_wdata.product_base  = in_ch.row_product_start;
      row_wdata.product_total = in_ch.row_product_count;
    end
    row_re = (state_r == S_IDLE) && in_xfer && is_step;
  end

  assign edge_we    = (state_r == S_IDLE) && in_xfer && (in_ch.command == CMD_WRITE_EDGE);
  assign edge_wdata = '{target: in_ch.target_node, cum_weight: in_ch.cum_weight};
  assign prod_we    = (state_r == S_IDLE) && in_xfer && (in_ch.command == CMD_WRITE_PRODUCT);

  // Edge reads: last weight, search probes, then the chosen target.
  always_comb begin
    edge_re    = 1'b0;
    edge_raddr = EDGE_AW'(row_q.edge_base + lo_r);
    if ((state_r == S_DECIDE) && use_weighted && (row_q.edge_total != '0)) begin
      edge_re    = 1'b1;
      edge_raddr = EDGE_AW'(row_q.edge_base + ESTART_W'(row_q.edge_total - 1'b1));
    end else if (state_r == S_SCHK) begin
      edge_re    = 1'b1;
      edge_raddr = (lo_r < hi_r) ? EDGE_AW'(row_q.edge_base + mid)
                                 : EDGE_AW'(row_q.edge_base + lo_r);
    end
  end

  assign prod_re    = (state_r == S_PDIV) && div_done;
  assign prod_raddr = pidx;

  // Divider serves both u = r*65536/cont_r and the product index.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {in_ch.random_value, 16'h0000};
    div_dvs   = {1'b0, cont_r};
    if ((state_r == S_IDLE) && in_xfer && is_step && !stop_walk && (cont_r != '0)) begin
      div_start = 1'b1;
    end else if (state_r == S_PSTART) begin
      div_start = 1'b1;
      div_dvd   = num_r;
      div_dvs   = DVS_W'(17'h10000 - {1'b0, ratio_r});
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          if (is_step && !stop_walk) begin
            state_nxt = (cont_r == '0) ? S_DECIDE : S_DIVU;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIVU:   if (div_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!use_weighted)                  state_nxt = S_PMUL;
        else if (row_q.edge_total == '0)    state_nxt = S_OUT;
        else                                state_nxt = S_LAST;
      end
      S_LAST:   state_nxt = S_SCHK;
      S_SCHK:   state_nxt = (lo_r < hi_r) ? S_SWAIT : S_TGT;
      S_SWAIT:  state_nxt = S_SCMP;
      S_SCMP:   state_nxt = S_SCHK;
      S_TGT:    state_nxt = S_OUT;
      S_PMUL:   state_nxt = S_PSTART;
      S_PSTART: state_nxt = S_PDIV;
      S_PDIV:   if (div_done) state_nxt = S_PRD;
      S_PRD:    state_nxt = S_OUT;
      S_OUT:    if (out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        res_node_r   <= '0;
        res_stop_r   <= is_step && stop_walk;
        res_status_r <= 1'b0;
        u_r          <= '0;
      end
      S_DIVU:   if (div_done) u_r <= div_quot[ECOUNT_W-1:0];
      S_DECIDE: begin
        lo_r         <= '0;
        hi_r         <= ESTART_W'(row_q.edge_total - 1'b1);
        res_status_r <= use_weighted && (row_q.edge_total == '0);
      end
      S_LAST:   lhs_r <= u_r * edge_q.cum_weight;
      S_SWAIT:  rhs_r <= edge_q.cum_weight * ratio_r;
      S_SCMP: begin
        if (lhs_r > {1'b0, rhs_r}) lo_r <= mid + 1'b1;
        else                       hi_r <= mid;
      end
      S_TGT:    res_node_r <= edge_q.target;
      S_PMUL:   num_r <= DVD_W'(DVD_W'(u_r - {1'b0, ratio_r}) *
                                DVD_W'(row_q.product_total));
      S_PRD:    res_node_r <= prod_q;
      default:  ;
    endcase
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = state_r == S_OUT;
  assign out_ch.next_node    = res_node_r;
  assign out_ch.walk_stopped = res_stop_r;
  assign out_ch.status       = res_status_r;

  logic [$bits(row_t)-1:0]  row_rdata;
  logic [$bits(edge_t)-1:0] edge_rdata;
  assign row_q  = row_t'(row_rdata);
  assign edge_q = edge_t'(edge_rdata);

  wrw_ram #(.WIDTH($bits(row_t)), .DEPTH(NODE_COUNT)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(NODE_W'(in_ch.node)), .rdata(row_rdata)
  );

  wrw_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGE_SLOTS)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(EDGE_AW'(in_ch.slot)), .wdata(edge_wdata),
    .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
  );

  wrw_ram #(.WIDTH(TARGET_W), .DEPTH(PRODUCT_SLOTS)) u_prod_ram (
    .clk(clk), .we(prod_we), .waddr(PROD_AW'(in_ch.slot)), .wdata(in_ch.target_node),
    .re(prod_re), .raddr(prod_raddr), .rdata(prod_q)
  );

  wrw_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_quot)
  );
endmodule
`default_nettype wire
